// ===== design/hip_pkg.sv =====
// Shared types and constants for the heat index polynomial core.
package hip_pkg;

    localparam int TEMP_W = 13;
    localparam int HUM_W  = 11;
    localparam int HI_W   = 16;

    localparam int CH_W   = 35;
    localparam int N_CH   = 3;
    localparam int ACC_W  = CH_W * N_CH;
    localparam int MUL_W  = 14;
    localparam int PROD_W = CH_W + 1 + MUL_W;

    localparam int RND_SH = 36;
    localparam int N_W    = ACC_W - RND_SH;
    localparam int REM_W  = 53;
    localparam int QUO_W  = 16;
    localparam int DIV_ST = QUO_W / 2;

    localparam int MAC_ST  = 12;
    localparam int PIPE_ST = MAC_ST + 2 + DIV_ST;

    typedef logic [ACC_W-1:0] acc_t;

    typedef struct packed {
        logic neg;
        logic over;
    } res_flag_t;

    // coefficient table scaled by 1e16, indexed [power of T][power of H]
    localparam acc_t COEF [4][4] = '{
        '{ 105'sd169230000000000000,  105'sd53794100000000000,
           105'sd72889800000000,      105'sd291583000000 },
        '{ 105'sd1852120000000000,   -105'sd1002540000000000,
          -105'sd8149710000000,       105'sd1974830000 },
        '{ 105'sd94169500000000,      105'sd3453720000000,
           105'sd102102000000,        105'sd8432960 },
        '{-105'sd386460000000,        105'sd14272100000,
          -105'sd218429000,          -105'sd481975 }
    };

    localparam acc_t HALF = ACC_W'(64'd10000000000000000) << 19;
    localparam logic [REM_W-1:0] DIV5 = 53'd152587890625;
    localparam logic [N_W-1:0]   QLIM = 69'd5000152587890625;

    localparam logic signed [HI_W-1:0] HI_MAX = 16'sh7FFF;
    localparam logic signed [HI_W-1:0] HI_MIN = 16'sh8000;

endpackage

// ===== design/hip_delay.sv =====
// Enabled register delay line for operands that ride alongside the arithmetic.
module hip_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= d;
            for (int k = 1; k < DEPTH; k++)
            begin
                tap_reg[k] <= tap_reg[k-1];
            end
        end
    end

    assign q = tap_reg[DEPTH-1];

endmodule

// ===== design/hip_mac.sv =====
// Two-stage multiply-add: res = acc * mul + addend, modulo 2^ACC_W.
module hip_mac (
    input  logic                             clk,
    input  logic                             en,
    input  hip_pkg::acc_t                    acc,
    input  logic signed [hip_pkg::MUL_W-1:0] mul,
    input  hip_pkg::acc_t                    addend,
    output hip_pkg::acc_t                    res
);

    import hip_pkg::*;

    logic signed [PROD_W-1:0] prod_next [N_CH];
    logic signed [PROD_W-1:0] prod_reg  [N_CH];
    acc_t                     add_reg;
    acc_t                     res_next;
    acc_t                     res_reg;

    always_comb
    begin
        for (int k = 0; k < N_CH; k++)
        begin
            prod_next[k] = $signed({1'b0, acc[k*CH_W +: CH_W]}) * mul;
        end
    end

    always_comb
    begin
        res_next = {{(ACC_W-PROD_W){prod_reg[0][PROD_W-1]}}, prod_reg[0]}
                 + {{(ACC_W-PROD_W-CH_W){prod_reg[1][PROD_W-1]}}, prod_reg[1],
                    {CH_W{1'b0}}}
                 + {prod_reg[2][ACC_W-2*CH_W-1:0], {(2*CH_W){1'b0}}}
                 + add_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            add_reg  <= addend;
            res_reg  <= res_next;
        end
    end

    assign res = res_reg;

endmodule

// ===== design/hip_rdiv.sv =====
// Round the wide sum to 1/16 degree and divide out the decimal scale, two quotient bits a stage.
module hip_rdiv (
    input  logic                          clk,
    input  logic                          en,
    input  hip_pkg::acc_t                 sum,
    output logic [hip_pkg::QUO_W-1:0]     quot,
    output hip_pkg::res_flag_t            flags
);

    import hip_pkg::*;

    acc_t             mag_next;
    acc_t             mag_reg;
    logic             neg_reg;
    acc_t             rnd_sum;
    logic [N_W-1:0]   rnd_n;
    res_flag_t        flag_next;

    logic [REM_W-1:0] rem_reg  [DIV_ST+1];
    logic [QUO_W-1:0] quo_reg  [DIV_ST+1];
    res_flag_t        flag_reg [DIV_ST+1];

    always_comb
    begin
        mag_next = sum[ACC_W-1] ? (~sum + ACC_W'(1)) : sum;
        rnd_sum  = mag_reg + HALF;
        rnd_n    = rnd_sum[ACC_W-1:RND_SH];
        flag_next.neg  = neg_reg;
        flag_next.over = (rnd_n >= QLIM);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg     <= mag_next;
            neg_reg     <= sum[ACC_W-1];
            rem_reg[0]  <= rnd_n[REM_W-1:0];
            quo_reg[0]  <= '0;
            flag_reg[0] <= flag_next;
        end
    end

    for (genvar k = 0; k < DIV_ST; k++)
    begin : g_div
        localparam int B1 = QUO_W - 1 - 2 * k;
        localparam int B0 = B1 - 1;
        localparam logic [REM_W-1:0] D1 = DIV5 << B1;
        localparam logic [REM_W-1:0] D0 = DIV5 << B0;

        logic             ge1;
        logic             ge0;
        logic [REM_W-1:0] rem_mid;
        logic [REM_W-1:0] rem_next;
        logic [QUO_W-1:0] quo_next;

        always_comb
        begin
            ge1      = (rem_reg[k] >= D1);
            rem_mid  = ge1 ? (rem_reg[k] - D1) : rem_reg[k];
            ge0      = (rem_mid >= D0);
            rem_next = ge0 ? (rem_mid - D0) : rem_mid;
            quo_next = quo_reg[k];
            quo_next[B1] = ge1;
            quo_next[B0] = ge0;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= rem_next;
                quo_reg[k+1]  <= quo_next;
                flag_reg[k+1] <= flag_reg[k];
            end
        end
    end

    assign quot  = quo_reg[DIV_ST];
    assign flags = flag_reg[DIV_ST];

endmodule

// ===== design/heat_index_polynomial_core.sv =====
// Top level of the heat index polynomial core: Horner pipeline, rounding divider, output skid.
// Pipeline: 23 register stages (12 multiply-add stages in the Horner chains, 2 rounding stages,
// 8 divide stages, the output register).
// Throughput: one transaction per cycle; the pipeline halts only while the skid slot is full.
// Reset (rst_n low, asynchronous) empties the pipeline, the output register and the skid slot.
module heat_index_polynomial_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [hip_pkg::TEMP_W-1:0]   temp_f,
    input  logic        [hip_pkg::HUM_W-1:0]    humidity,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [hip_pkg::HI_W-1:0]     apparent_temp,
    output logic                                saturated
);

    import hip_pkg::*;

    logic                     adv;
    logic [PIPE_ST-1:0]       vld_reg;
    logic [PIPE_ST-1:0]       vld_next;

    logic [HUM_W-1:0]         hum_d2;
    logic [HUM_W-1:0]         hum_d4;
    logic [TEMP_W-1:0]        temp_d6;
    logic [TEMP_W-1:0]        temp_d8;
    logic [TEMP_W-1:0]        temp_d10;

    logic signed [MUL_W-1:0]  mh0;
    logic signed [MUL_W-1:0]  mh2;
    logic signed [MUL_W-1:0]  mh4;
    logic signed [MUL_W-1:0]  mt6;
    logic signed [MUL_W-1:0]  mt8;
    logic signed [MUL_W-1:0]  mt10;

    acc_t                     qa [4];
    acc_t                     qb [4];
    acc_t                     qh [4];
    acc_t                     q1_d2;
    acc_t                     q0_d4;
    acc_t                     sa;
    acc_t                     sb;
    acc_t                     sfin;

    logic [QUO_W-1:0]         quot;
    res_flag_t                flags;
    logic signed [HI_W-1:0]   hi_item;
    logic                     sat_item;
    logic                     take;

    logic                     out_vld_reg;
    logic                     out_vld_next;
    logic signed [HI_W-1:0]   out_hi_reg;
    logic signed [HI_W-1:0]   out_hi_next;
    logic                     out_sat_reg;
    logic                     out_sat_next;
    logic                     skid_vld_reg;
    logic                     skid_vld_next;
    logic signed [HI_W-1:0]   skid_hi_reg;
    logic signed [HI_W-1:0]   skid_hi_next;
    logic                     skid_sat_reg;
    logic                     skid_sat_next;

    assign adv      = ~skid_vld_reg;
    assign in_ready = adv;
    assign vld_next = {vld_reg[PIPE_ST-2:0], in_valid};

    hip_delay #(.WIDTH(HUM_W),  .DEPTH(2)) u_hum_d2  (.clk(clk), .en(adv), .d(humidity), .q(hum_d2));
    hip_delay #(.WIDTH(HUM_W),  .DEPTH(2)) u_hum_d4  (.clk(clk), .en(adv), .d(hum_d2),   .q(hum_d4));
    hip_delay #(.WIDTH(TEMP_W), .DEPTH(6)) u_temp_d6 (.clk(clk), .en(adv), .d(temp_f),   .q(temp_d6));
    hip_delay #(.WIDTH(TEMP_W), .DEPTH(2)) u_temp_d8 (.clk(clk), .en(adv), .d(temp_d6),  .q(temp_d8));
    hip_delay #(.WIDTH(TEMP_W), .DEPTH(2)) u_temp_d10(.clk(clk), .en(adv), .d(temp_d8),  .q(temp_d10));

    assign mh0  = $signed({{(MUL_W-HUM_W){1'b0}}, humidity});
    assign mh2  = $signed({{(MUL_W-HUM_W){1'b0}}, hum_d2});
    assign mh4  = $signed({{(MUL_W-HUM_W){1'b0}}, hum_d4});
    assign mt6  = $signed({{(MUL_W-TEMP_W){temp_d6[TEMP_W-1]}}, temp_d6});
    assign mt8  = $signed({{(MUL_W-TEMP_W){temp_d8[TEMP_W-1]}}, temp_d8});
    assign mt10 = $signed({{(MUL_W-TEMP_W){temp_d10[TEMP_W-1]}}, temp_d10});

    for (genvar i = 0; i < 4; i++)
    begin : g_hum
        hip_mac u_h1 (
            .clk(clk), .en(adv), .acc(COEF[i][3]), .mul(mh0),
            .addend(COEF[i][2] << 4), .res(qa[i])
        );
        hip_mac u_h2 (
            .clk(clk), .en(adv), .acc(qa[i]), .mul(mh2),
            .addend(COEF[i][1] << 8), .res(qb[i])
        );
        hip_mac u_h3 (
            .clk(clk), .en(adv), .acc(qb[i]), .mul(mh4),
            .addend(COEF[i][0] << 12), .res(qh[i])
        );
    end

    hip_delay #(.WIDTH(ACC_W), .DEPTH(2)) u_q1_d2 (.clk(clk), .en(adv), .d(qh[1]), .q(q1_d2));
    hip_delay #(.WIDTH(ACC_W), .DEPTH(4)) u_q0_d4 (.clk(clk), .en(adv), .d(qh[0]), .q(q0_d4));

    hip_mac u_t1 (
        .clk(clk), .en(adv), .acc(qh[3]), .mul(mt6), .addend(qh[2] << 4), .res(sa)
    );
    hip_mac u_t2 (
        .clk(clk), .en(adv), .acc(sa), .mul(mt8), .addend(q1_d2 << 8), .res(sb)
    );
    hip_mac u_t3 (
        .clk(clk), .en(adv), .acc(sb), .mul(mt10), .addend(q0_d4 << 12), .res(sfin)
    );

    hip_rdiv u_rdiv (
        .clk(clk), .en(adv), .sum(sfin), .quot(quot), .flags(flags)
    );

    always_comb
    begin
        priority if (flags.over)
        begin
            sat_item = 1'b1;
            hi_item  = flags.neg ? HI_MIN : HI_MAX;
        end
        else if (flags.neg)
        begin
            sat_item = 1'b0;
            hi_item  = HI_W'(-quot);
        end
        else if (quot[QUO_W-1])
        begin
            sat_item = 1'b1;
            hi_item  = HI_MAX;
        end
        else
        begin
            sat_item = 1'b0;
            hi_item  = quot;
        end
    end

    assign take = adv & vld_reg[PIPE_ST-1];

    always_comb
    begin
        out_vld_next  = out_vld_reg;
        out_hi_next   = out_hi_reg;
        out_sat_next  = out_sat_reg;
        skid_vld_next = skid_vld_reg;
        skid_hi_next  = skid_hi_reg;
        skid_sat_next = skid_sat_reg;
        priority if (out_vld_reg && !out_ready)
        begin
            // hold the stalled transaction; park the arriving one
            if (take)
            begin
                skid_vld_next = 1'b1;
                skid_hi_next  = hi_item;
                skid_sat_next = sat_item;
            end
        end
        else if (skid_vld_reg)
        begin
            out_vld_next  = 1'b1;
            out_hi_next   = skid_hi_reg;
            out_sat_next  = skid_sat_reg;
            skid_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = take;
            out_hi_next  = hi_item;
            out_sat_next = sat_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                vld_reg <= vld_next;
            end
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_hi_reg   <= out_hi_next;
        out_sat_reg  <= out_sat_next;
        skid_hi_reg  <= skid_hi_next;
        skid_sat_reg <= skid_sat_next;
    end

    assign out_valid     = out_vld_reg;
    assign apparent_temp = out_hi_reg;
    assign saturated     = out_sat_reg;

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the heat index polynomial core: corner and random transactions.
`timescale 1ns / 100ps

module testbench;

    localparam int TW = hip_pkg::TEMP_W;
    localparam int HW = hip_pkg::HUM_W;
    localparam int OW = hip_pkg::HI_W;

    localparam int RANDOM_PER_PHASE = 645;
    localparam int DRAIN_LIMIT      = 20000;
    localparam int TAIL_CYCLES      = 40;

    typedef struct packed {
        logic signed [OW-1:0] apparent_temp;
        logic                 saturated;
    } heat_result_t;

    class apparent_scoreboard;
        localparam logic [127:0] E16        = 128'd10000000000000000;
        localparam logic [127:0] ROUND_HALF = E16 << 19;
        localparam logic [127:0] ROUND_DIV  = E16 << 20;
        localparam logic signed [OW-1:0] HEAT_MAX = 16'sh7FFF;
        localparam logic signed [OW-1:0] HEAT_MIN = 16'sh8000;

        heat_result_t pending_q[$];
        int           mismatches;
        int           noted;
        int           checked;
        int           clamped;

        function new();
            mismatches = 0;
            noted      = 0;
            checked    = 0;
            clamped    = 0;
        endfunction

        // coefficients scaled by 1e16, index is power of T times 4 plus power of H
        function longint coef_e16(int idx);
            case (idx)
                0:       return 64'sd169230000000000000;
                1:       return 64'sd53794100000000000;
                2:       return 64'sd72889800000000;
                3:       return 64'sd291583000000;
                4:       return 64'sd1852120000000000;
                5:       return -64'sd1002540000000000;
                6:       return -64'sd8149710000000;
                7:       return 64'sd1974830000;
                8:       return 64'sd94169500000000;
                9:       return 64'sd3453720000000;
                10:      return 64'sd102102000000;
                11:      return 64'sd8432960;
                12:      return -64'sd386460000000;
                13:      return 64'sd14272100000;
                14:      return -64'sd218429000;
                default: return -64'sd481975;
            endcase
        endfunction

        function heat_result_t predict_apparent(logic signed [TW-1:0] t, logic [HW-1:0] h);
            logic signed [127:0] tw;
            logic signed [127:0] hw;
            logic signed [127:0] term;
            logic signed [127:0] total;
            logic [127:0]        mag;
            logic [127:0]        quo;
            logic                neg;
            heat_result_t        r;
            tw    = t;
            hw    = 128'(h);
            total = '0;
            for (int ti = 0; ti < 4; ti++) begin
                for (int hj = 0; hj < 4; hj++) begin
                    term = coef_e16(ti * 4 + hj);
                    repeat (ti) term = term * tw;
                    repeat (hj) term = term * hw;
                    term  = term <<< (4 * (6 - ti - hj));
                    total = total + term;
                end
            end
            neg = total[127];
            mag = neg ? -total : total;
            quo = (mag + ROUND_HALF) / ROUND_DIV;
            r.saturated = 1'b0;
            if (quo > 128'd32768) begin
                r.saturated     = 1'b1;
                r.apparent_temp = neg ? HEAT_MIN : HEAT_MAX;
            end else if (neg) begin
                r.apparent_temp = -quo[OW-1:0];
            end else if (quo > 128'd32767) begin
                r.saturated     = 1'b1;
                r.apparent_temp = HEAT_MAX;
            end else begin
                r.apparent_temp = quo[OW-1:0];
            end
            return r;
        endfunction

        function void note_sample(logic signed [TW-1:0] t, logic [HW-1:0] h);
            pending_q.push_back(predict_apparent(t, h));
            noted++;
        endfunction

        function void check_result(logic signed [OW-1:0] hi, logic sat);
            heat_result_t want;
            if (pending_q.size() == 0) begin
                $error("unexpected transaction: apparent_temp %0d saturated %0b", hi, sat);
                mismatches++;
                return;
            end
            want = pending_q.pop_front();
            checked++;
            if (want.saturated) clamped++;
            if (hi !== want.apparent_temp) begin
                $error("apparent_temp: expected %0d, actual %0d", want.apparent_temp, hi);
                mismatches++;
            end
            if (sat !== want.saturated) begin
                $error("saturated: expected %0b, actual %0b", want.saturated, sat);
                mismatches++;
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic signed [TW-1:0] temp_f;
    logic [HW-1:0]        humidity;
    logic                 out_valid;
    logic                 out_ready;
    logic signed [OW-1:0] apparent_temp;
    logic                 saturated;

    apparent_scoreboard   board;
    int                   send_idle_pct;
    int                   recv_idle_pct;

    heat_index_polynomial_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .temp_f        (temp_f),
        .humidity      (humidity),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .apparent_temp (apparent_temp),
        .saturated     (saturated)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            board.check_result(apparent_temp, saturated);
        end
    end

    task automatic send_sample(input logic signed [TW-1:0] t, input logic [HW-1:0] h);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        temp_f   <= t;
        humidity <= h;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        board.note_sample(t, h);
        @(negedge clk);
    endtask

    task automatic send_random_sample();
        int                   tv;
        logic signed [TW-1:0] t;
        logic [HW-1:0]        h;
        if ($urandom_range(99) < 85)
        begin
            tv = int'($urandom_range(3040)) - 640;
            t  = tv[TW-1:0];
            h  = HW'($urandom_range(1600));
        end
        else
        begin
            t = TW'($urandom);
            h = HW'($urandom);
        end
        send_sample(t, h);
    endtask

    initial
    begin
        #5_000_000;
        $display("[heat_index_polynomial_core] ERROR");
        $finish;
    end

    initial
    begin
        int leftover;
        int waited;
        board         = new();
        send_idle_pct = 17;
        recv_idle_pct = 70;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        temp_f        = '0;
        humidity      = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_sample(-13'sd4096, 11'd0);
        send_sample(-13'sd4096, 11'd2047);
        send_sample(13'sd4095, 11'd0);
        send_sample(13'sd4095, 11'd2047);
        send_sample(-13'sd640, 11'd0);
        send_sample(-13'sd640, 11'd1600);
        send_sample(13'sd2400, 11'd0);
        send_sample(13'sd2400, 11'd1600);
        send_sample(13'sd0, 11'd0);
        send_sample(-13'sd1, 11'd1024);
        send_sample(13'sd1, 11'd1);
        send_sample(13'sd1280, 11'd800);
        send_sample(13'sd1600, 11'd1280);
        send_sample(13'sd1440, 11'd1600);
        send_sample(13'sd0, 11'd2047);
        send_sample(13'sd4095, 11'd1024);
        send_sample(-13'sd4096, 11'd1024);
        send_sample(13'sd2400, 11'd2047);
        send_sample(-13'sd2048, 11'd2047);
        send_sample(13'sd2048, 11'd2047);

        repeat (RANDOM_PER_PHASE) send_random_sample();
        send_idle_pct = 70;
        recv_idle_pct = 17;
        repeat (RANDOM_PER_PHASE) send_random_sample();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (RANDOM_PER_PHASE) send_random_sample();
        in_valid <= 1'b0;

        waited = 0;
        while (board.pending_q.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        leftover = board.pending_q.size();
        if (leftover != 0)
        begin
            $error("%0d expected transactions never arrived", leftover);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("sent %0d samples (corners, in-range and full-field random)", board.noted);
        $display("under three stall mixes; checked %0d results, %0d of them clamped",
                 board.checked, board.clamped);
        if (board.mismatches == 0 && leftover == 0)
        begin
            $display("[heat_index_polynomial_core] OK");
        end
        else
        begin
            $display("[heat_index_polynomial_core] ERROR");
        end
        $finish;
    end

endmodule
